// ===== design/peak_hold_range_decimator_macros.svh =====
// ----------------------------------------------------------------------------
// peak hold range decimator assertion macros
// shared helpers for concurrent checks on aclk with synchronous reset
// ----------------------------------------------------------------------------
`ifndef PEAK_HOLD_RANGE_DECIMATOR_MACROS_SVH
`define PEAK_HOLD_RANGE_DECIMATOR_MACROS_SVH

// same-cycle implication
`define PHRD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("phrd check failed");

// next-cycle implication
`define PHRD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("phrd check failed");

`endif

// ===== design/phrd_pkg.sv =====
// ----------------------------------------------------------------------------
// phrd_pkg
// types and constants shared by the peak hold range decimator
// ----------------------------------------------------------------------------
`default_nettype none

package phrd_pkg;

    localparam int DEF_MAX_SAMPLES = 4096;
    localparam int DEF_MAX_BINS    = 64;

    localparam int CFG_IW = 2;
    localparam logic [CFG_IW-1:0] REG_MASS_MIN       = 2'd0;
    localparam logic [CFG_IW-1:0] REG_MASS_MAX       = 2'd1;
    localparam logic [CFG_IW-1:0] REG_BINS_REQUESTED = 2'd2;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_LO_RD,
        ST_LO_CHK,
        ST_HI_RD,
        ST_HI_CHK,
        ST_SETUP,
        ST_WALK_RD,
        ST_WALK_UPD,
        ST_FLUSH,
        ST_EMPTY,
        ST_OUT_RD,
        ST_OUT_LOAD,
        ST_OUT_HOLD
    } phrd_state_t;

    typedef struct packed {
        logic start;
        logic step;
    } phrd_bin_ctl_t;

endpackage

`default_nettype wire

// ===== design/phrd_bin_index.sv =====
// ----------------------------------------------------------------------------
// phrd_bin_index
// incremental floor(j*(nb-1)/d) bin counter, one sample per step
// ----------------------------------------------------------------------------
`default_nettype none

module phrd_bin_index #(
    parameter int AW = 12,
    parameter int BW = 6
) (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  phrd_pkg::phrd_bin_ctl_t ctl,
    input  wire  [BW-1:0]          nbm1,
    input  wire  [AW-1:0]          dspan,
    output logic [BW-1:0]          bin
);
    import phrd_pkg::*;

    localparam int SW = ((AW > BW) ? AW : BW) + 1;

    logic [SW-1:0] acc_reg, acc_next;
    logic [BW-1:0] bin_reg, bin_next;
    logic [SW-1:0] sum;
    logic [SW-1:0] d_ext;

    always_comb begin
        d_ext    = SW'(dspan);
        sum      = acc_reg + SW'(nbm1);
        acc_next = acc_reg;
        bin_next = bin_reg;
        if (ctl.start) begin
            acc_next = '0;
            bin_next = '0;
        end else if (ctl.step) begin
            // nb-1 never exceeds d, so one subtract keeps acc below d
            if (sum >= d_ext) begin
                acc_next = sum - d_ext;
                bin_next = bin_reg + BW'(1);
            end else begin
                acc_next = sum;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
            bin_reg <= '0;
        end else begin
            acc_reg <= acc_next;
            bin_reg <= bin_next;
        end
    end

    assign bin = bin_reg;

endmodule

`default_nettype wire

// ===== design/peak_hold_range_decimator.sv =====
// ----------------------------------------------------------------------------
// peak_hold_range_decimator
// stores one spectrum, trims it to a mass window and keeps the peak per bin
// ----------------------------------------------------------------------------
//  channel  direction  ports                                   beat
//  s_       in         s_valid s_ready sample fields           one sample
//  m_       out        m_valid m_ready bin fields              one bin
//  cfg_     in         cfg_valid cfg_ready cfg_index cfg_data  one register
//
//  load: one sample beat per cycle while s_valid is high, written into the sample memory
//  after the last sample: lower and upper scan use a read and a check state per
//  sample visited, the bin walk a read and an update state per sample in span
//  each bin then: read, load, hold until m_ready; s_ready is low meanwhile
//  reset clears control only; the memories need no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module peak_hold_range_decimator #(
    parameter int MAX_SAMPLES = phrd_pkg::DEF_MAX_SAMPLES,
    parameter int MAX_BINS    = phrd_pkg::DEF_MAX_BINS
) (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire  [31:0]                  s_sample_mass,
    input  wire  signed [31:0]           s_sample_intensity,
    input  wire                          s_last_sample,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic [31:0]                  m_bin_mass,
    output logic signed [31:0]           m_bin_intensity,
    output logic                         m_last_bin,
    output logic                         m_range_empty,
    input  wire                          cfg_valid,
    output logic                         cfg_ready,
    input  wire  [phrd_pkg::CFG_IW-1:0]  cfg_index,
    input  wire  [31:0]                  cfg_data
);
    import phrd_pkg::*;

    localparam int AW  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int CW  = $clog2(MAX_SAMPLES + 1);
    localparam int BW  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
    localparam int XW  = (CW > 7) ? CW : 7;

    // configuration registers
    logic [31:0] mass_min_reg, mass_max_reg;
    logic [6:0]  bins_req_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mass_min_reg <= '0;
            mass_max_reg <= '1;
            bins_req_reg <= 7'd64;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                REG_MASS_MIN:       mass_min_reg <= cfg_data;
                REG_MASS_MAX:       mass_max_reg <= cfg_data;
                REG_BINS_REQUESTED: bins_req_reg <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // control and datapath registers
    phrd_state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] j_reg, j_next;
    logic [AW-1:0] lo_reg, lo_next;
    logic [AW-1:0] hi_reg, hi_next;
    logic [BW-1:0] nbm1_reg, nbm1_next;
    logic [BW-1:0] k_reg, k_next;
    logic [31:0]   cur_mass_reg, cur_mass_next;
    logic [31:0]   cur_int_reg, cur_int_next;
    logic [BW-1:0] cur_bin_reg, cur_bin_next;
    logic [31:0]   out_mass_reg, out_mass_next;
    logic [31:0]   out_int_reg, out_int_next;
    logic          out_last_reg, out_last_next;
    logic          out_empty_reg, out_empty_next;

    // sample memory: {mass, intensity}
    logic [63:0]   sample_mem [MAX_SAMPLES];
    logic [63:0]   samp_rd;
    logic          samp_we;

    // per-bin peak memory
    logic [63:0]   peak_mem [MAX_BINS];
    logic [63:0]   peak_rd;
    logic          peak_we;
    logic [63:0]   peak_wdata;

    logic          s_beat;
    logic [AW-1:0] last_idx;
    logic [31:0]   rd_mass;
    logic [31:0]   rd_int;
    logic [AW-1:0] dspan;
    logic [CW-1:0] span;
    logic [6:0]    nb_clamp;
    logic [XW-1:0] nb_sel;
    logic [BW-1:0] cur_idx;
    logic          take;

    phrd_bin_ctl_t bin_ctl;

    assign s_beat   = s_valid && s_ready;
    assign samp_we  = s_beat && (count_reg < CW'(MAX_SAMPLES));
    assign last_idx = AW'(count_reg - CW'(1));
    assign rd_mass  = samp_rd[63:32];
    assign rd_int   = samp_rd[31:0];
    assign dspan    = hi_reg - lo_reg;
    assign span     = CW'(dspan) + CW'(1);

    always_ff @(posedge aclk) begin
        if (samp_we) begin
            sample_mem[count_reg[AW-1:0]] <= {s_sample_mass, s_sample_intensity};
        end
        samp_rd <= sample_mem[j_reg];
    end

    always_ff @(posedge aclk) begin
        if (peak_we) begin
            peak_mem[cur_bin_reg] <= peak_wdata;
        end
        peak_rd <= peak_mem[k_reg];
    end

    phrd_bin_index #(
        .AW (AW),
        .BW (BW)
    ) u_bin_index (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (bin_ctl),
        .nbm1    (nbm1_reg),
        .dspan   (dspan),
        .bin     (cur_idx)
    );

    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        j_next         = j_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        nbm1_next      = nbm1_reg;
        k_next         = k_reg;
        cur_mass_next  = cur_mass_reg;
        cur_int_next   = cur_int_reg;
        cur_bin_next   = cur_bin_reg;
        out_mass_next  = out_mass_reg;
        out_int_next   = out_int_reg;
        out_last_next  = out_last_reg;
        out_empty_next = out_empty_reg;
        bin_ctl        = '0;
        peak_we        = 1'b0;
        peak_wdata     = {cur_mass_reg, cur_int_reg};
        s_ready        = 1'b0;
        m_valid        = 1'b0;
        take           = 1'b0;

        // bins_requested clamped to 1..MAX_BINS, then to the span
        if (bins_req_reg == 7'd0) begin
            nb_clamp = 7'd1;
        end else if (bins_req_reg > 7'(MAX_BINS)) begin
            nb_clamp = 7'(MAX_BINS);
        end else begin
            nb_clamp = bins_req_reg;
        end
        nb_sel = (XW'(nb_clamp) > XW'(span)) ? XW'(span) : XW'(nb_clamp);

        unique case (state_reg)
            ST_LOAD: begin
                s_ready = 1'b1;
                if (s_beat) begin
                    if (samp_we) begin
                        count_next = count_reg + CW'(1);
                    end
                    if (s_last_sample) begin
                        j_next     = '0;
                        state_next = ST_LO_RD;
                    end
                end
            end
            ST_LO_RD: begin
                state_next = ST_LO_CHK;
            end
            ST_LO_CHK: begin
                // first sample at or above the lower bound, widened by one
                if (rd_mass >= mass_min_reg) begin
                    lo_next    = (j_reg == '0) ? '0 : j_reg - AW'(1);
                    j_next     = last_idx;
                    state_next = ST_HI_RD;
                end else if (j_reg == last_idx) begin
                    lo_next    = last_idx;
                    j_next     = last_idx;
                    state_next = ST_HI_RD;
                end else begin
                    j_next     = j_reg + AW'(1);
                    state_next = ST_LO_RD;
                end
            end
            ST_HI_RD: begin
                state_next = ST_HI_CHK;
            end
            ST_HI_CHK: begin
                // last sample at or below the upper bound, widened by one
                if (rd_mass <= mass_max_reg) begin
                    hi_next    = (j_reg == last_idx) ? j_reg : j_reg + AW'(1);
                    state_next = ST_SETUP;
                end else if (j_reg == '0) begin
                    hi_next    = '0;
                    state_next = ST_SETUP;
                end else begin
                    j_next     = j_reg - AW'(1);
                    state_next = ST_HI_RD;
                end
            end
            ST_SETUP: begin
                if (hi_reg < lo_reg) begin
                    state_next = ST_EMPTY;
                end else begin
                    nbm1_next     = BW'(nb_sel - XW'(1));
                    bin_ctl.start = 1'b1;
                    j_next        = lo_reg;
                    cur_bin_next  = '0;
                    state_next    = ST_WALK_RD;
                end
            end
            ST_WALK_RD: begin
                state_next = ST_WALK_UPD;
            end
            ST_WALK_UPD: begin
                // a new bin retires the held peak; ties go to the later sample
                take = (j_reg == lo_reg) || (cur_idx != cur_bin_reg) ||
                       ($signed(rd_int) >= $signed(cur_int_reg));
                if ((j_reg != lo_reg) && (cur_idx != cur_bin_reg)) begin
                    peak_we = 1'b1;
                end
                if (take) begin
                    cur_mass_next = rd_mass;
                    cur_int_next  = rd_int;
                    cur_bin_next  = cur_idx;
                end
                if (j_reg == hi_reg) begin
                    state_next = ST_FLUSH;
                end else begin
                    j_next       = j_reg + AW'(1);
                    bin_ctl.step = 1'b1;
                    state_next   = ST_WALK_RD;
                end
            end
            ST_FLUSH: begin
                peak_we    = 1'b1;
                k_next     = '0;
                state_next = ST_OUT_RD;
            end
            ST_EMPTY: begin
                out_mass_next  = '0;
                out_int_next   = '0;
                out_last_next  = 1'b1;
                out_empty_next = 1'b1;
                state_next     = ST_OUT_HOLD;
            end
            ST_OUT_RD: begin
                state_next = ST_OUT_LOAD;
            end
            ST_OUT_LOAD: begin
                out_mass_next  = peak_rd[63:32];
                out_int_next   = peak_rd[31:0];
                out_last_next  = (k_reg == nbm1_reg);
                out_empty_next = 1'b0;
                state_next     = ST_OUT_HOLD;
            end
            ST_OUT_HOLD: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    if (out_last_reg) begin
                        count_next = '0;
                        state_next = ST_LOAD;
                    end else begin
                        k_next     = k_reg + BW'(1);
                        state_next = ST_OUT_RD;
                    end
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        j_reg         <= j_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        nbm1_reg      <= nbm1_next;
        k_reg         <= k_next;
        cur_mass_reg  <= cur_mass_next;
        cur_int_reg   <= cur_int_next;
        cur_bin_reg   <= cur_bin_next;
        out_mass_reg  <= out_mass_next;
        out_int_reg   <= out_int_next;
        out_last_reg  <= out_last_next;
        out_empty_reg <= out_empty_next;
    end

    assign m_bin_mass      = out_mass_reg;
    assign m_bin_intensity = out_int_reg;
    assign m_last_bin      = out_last_reg;
    assign m_range_empty   = out_empty_reg;

endmodule

`default_nettype wire

// ===== design/phrd_checker.sv =====
// ----------------------------------------------------------------------------
// phrd_checker
// port-level checks on the peak hold range decimator
// ----------------------------------------------------------------------------
`default_nettype none

`include "peak_hold_range_decimator_macros.svh"

module phrd_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_ready,
    input wire        m_valid,
    input wire        m_ready,
    input wire [31:0] m_bin_mass,
    input wire [31:0] m_bin_intensity,
    input wire        m_last_bin,
    input wire        m_range_empty
);
    // input is closed while results drain
    `PHRD_ASSERT_SAME(a_no_overlap, m_valid, !s_ready)
    // stalled result beat holds
    `PHRD_ASSERT_NEXT(a_hold, m_valid && !m_ready, m_valid && $stable(m_bin_mass))
    // empty marker is a lone zero beat
    `PHRD_ASSERT_SAME(a_empty, m_valid && m_range_empty,
        m_last_bin && (m_bin_mass == 32'd0) && (m_bin_intensity == 32'd0))
    // after the final bin the block returns to loading
    `PHRD_ASSERT_NEXT(a_done, m_valid && m_ready && m_last_bin, !m_valid && s_ready)

endmodule

bind peak_hold_range_decimator phrd_checker u_phrd_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_bin_mass      (m_bin_mass),
    .m_bin_intensity (m_bin_intensity),
    .m_last_bin      (m_last_bin),
    .m_range_empty   (m_range_empty)
);

`default_nettype wire

// ===== tb/peak_hold_range_decimator_tb.sv =====
// ----------------------------------------------------------------------------
// peak_hold_range_decimator_tb
// streams spectra through the decimator under random valid/ready idling,
// predicts every bin from a local copy of the sample store and the registers,
// and compares each result beat field by field against the oldest prediction
// ----------------------------------------------------------------------------
`default_nettype none

typedef struct {
    logic [31:0]        mass;
    logic signed [31:0] intensity;
    logic               last_bin;
    logic               range_empty;
} peak_bin_t;

class peak_bin_scoreboard;
    localparam int STORE_DEPTH = phrd_pkg::DEF_MAX_SAMPLES;
    localparam int BIN_LIMIT   = phrd_pkg::DEF_MAX_BINS;

    logic [31:0] window_lo;
    logic [31:0] window_hi;
    logic [6:0]  bins_wanted;

    logic [31:0] held_mass [STORE_DEPTH];
    logic [31:0] held_inten[STORE_DEPTH];
    int          held_count;

    peak_bin_t   pending_bins[$];
    int          fail_count;

    function new();
        window_lo   = '0;
        window_hi   = '1;
        bins_wanted = 7'd64;
        held_count  = 0;
        fail_count  = 0;
    endfunction

    // mirror of a register write
    function void write_reg(logic [phrd_pkg::CFG_IW-1:0] idx, logic [31:0] data);
        case (idx)
            phrd_pkg::REG_MASS_MIN:       window_lo   = data;
            phrd_pkg::REG_MASS_MAX:       window_hi   = data;
            phrd_pkg::REG_BINS_REQUESTED: bins_wanted = data[6:0];
            default: ;
        endcase
    endfunction

    // accepted sample beat; a last sample reduces the stored spectrum
    function void note_sample(logic [31:0] m, logic [31:0] v, logic is_last);
        longint    lo, hi, nb, count, b, prev;
        bit        first;
        peak_bin_t e;
        logic [31:0] pk_mass[BIN_LIMIT];
        logic [31:0] pk_inten[BIN_LIMIT];
        if (held_count < STORE_DEPTH) begin
            held_mass[held_count]  = m;
            held_inten[held_count] = v;
            held_count++;
        end
        if (!is_last) return;
        count      = held_count;
        held_count = 0;
        for (lo = 0; lo < count; lo++)
            if (held_mass[lo] >= window_lo) break;
        for (hi = count - 1; hi >= 0; hi--)
            if (held_mass[hi] <= window_hi) break;
        if (lo != 0) lo--;
        if (hi != count - 1) hi++;
        if (hi < lo) begin
            e.mass = '0; e.intensity = '0; e.last_bin = 1'b1; e.range_empty = 1'b1;
            pending_bins.push_back(e);
            return;
        end
        nb = bins_wanted;
        if (nb < 1) nb = 1;
        if (nb > BIN_LIMIT) nb = BIN_LIMIT;
        if (nb > hi - lo + 1) nb = hi - lo + 1;
        foreach (pk_mass[k]) begin
            pk_mass[k]  = '0;
            pk_inten[k] = '0;
        end
        prev = 0;
        for (longint i = lo; i <= hi; i++) begin
            b = (hi > lo) ? ((i - lo) * (nb - 1)) / (hi - lo) : 0;
            if (b > nb - 1) b = nb - 1;
            first = (i == lo) || (b != prev);
            if (first || $signed(held_inten[i]) >= $signed(pk_inten[b])) begin
                pk_inten[b] = held_inten[i];
                pk_mass[b]  = held_mass[i];
            end
            prev = b;
        end
        for (longint k = 0; k < nb; k++) begin
            e.mass        = pk_mass[k];
            e.intensity   = pk_inten[k];
            e.last_bin    = (k == nb - 1);
            e.range_empty = 1'b0;
            pending_bins.push_back(e);
        end
    endfunction

    function void check_bin(peak_bin_t got);
        peak_bin_t e;
        if (pending_bins.size() == 0) begin
            $error("bin beat with nothing expected: mass %h intensity %h", got.mass,
                   got.intensity);
            fail_count++;
            return;
        end
        e = pending_bins.pop_front();
        if (got.mass !== e.mass) begin
            $error("bin_mass expected %h actual %h", e.mass, got.mass);
            fail_count++;
        end
        if (got.intensity !== e.intensity) begin
            $error("bin_intensity expected %h actual %h", e.intensity, got.intensity);
            fail_count++;
        end
        if (got.last_bin !== e.last_bin) begin
            $error("last_bin expected %b actual %b", e.last_bin, got.last_bin);
            fail_count++;
        end
        if (got.range_empty !== e.range_empty) begin
            $error("range_empty expected %b actual %b", e.range_empty, got.range_empty);
            fail_count++;
        end
    endfunction
endclass

module peak_hold_range_decimator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import phrd_pkg::*;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [31:0]          s_sample_mass;
    logic signed [31:0]   s_sample_intensity;
    logic                 s_last_sample;
    logic                 m_valid;
    logic                 m_ready;
    logic [31:0]          m_bin_mass;
    logic signed [31:0]   m_bin_intensity;
    logic                 m_last_bin;
    logic                 m_range_empty;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IW-1:0]    cfg_index;
    logic [31:0]          cfg_data;

    peak_bin_scoreboard   bins_sb;
    bit                   quiet;        // no idling on either side
    int                   stall_left;
    int                   sample_total;

    peak_hold_range_decimator u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_sample_mass      (s_sample_mass),
        .s_sample_intensity (s_sample_intensity),
        .s_last_sample      (s_last_sample),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_bin_mass         (m_bin_mass),
        .m_bin_intensity    (m_bin_intensity),
        .m_last_bin         (m_last_bin),
        .m_range_empty      (m_range_empty),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    // 4 ns clock
    always begin
        aclk = 1'b1;
        #2;
        aclk = 1'b0;
        #2;
    end

    // result side back-pressure in random-length bursts
    always @(negedge aclk) begin
        if (quiet || !aresetn) begin
            stall_left = 0;
            m_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_ready <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 2);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // result monitor, sampled at the rising edge
    always @(posedge aclk) begin
        peak_bin_t got;
        if (aresetn && m_valid && m_ready) begin
            got.mass        = m_bin_mass;
            got.intensity   = m_bin_intensity;
            got.last_bin    = m_last_bin;
            got.range_empty = m_range_empty;
            bins_sb.check_bin(got);
        end
    end

    // one sample beat; called and returns at a falling edge
    task automatic send_sample(logic [31:0] m, logic [31:0] v, logic is_last);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_valid            <= 1'b1;
        s_sample_mass      <= m;
        s_sample_intensity <= v;
        s_last_sample      <= is_last;
        do @(posedge aclk); while (!s_ready);
        bins_sb.note_sample(m, v, is_last);
        sample_total++;
        @(negedge aclk);
        if (is_last) begin
            // block is reducing now, so the extra wait costs nothing
            s_valid <= 1'b0;
            @(negedge aclk);
        end
    endtask

    // wait for every bin of the last spectrum, then let the block settle
    task automatic drain();
        while (bins_sb.pending_bins.size() != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    // register write, only issued once the block is idle
    task automatic write_reg(logic [CFG_IW-1:0] idx, logic [31:0] data);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        bins_sb.write_reg(idx, data);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] pick_intensity();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom_range(0, 3);     // ties
            3: return -$urandom_range(1, 3);
            default: return $urandom;
        endcase
    endfunction

    // one spectrum; ascending masses from base when sorted, else random masses
    task automatic send_spectrum(int n, bit sorted, logic [31:0] base, int step_max);
        logic [31:0] m;
        m = base;
        for (int i = 0; i < n; i++) begin
            if (sorted) m = m + $urandom_range(0, step_max);
            else m = $urandom;
            send_sample(m, pick_intensity(), i == n - 1);
        end
    endtask

    task automatic random_window();
        logic [31:0] lo;
        logic [31:0] hi;
        lo = $urandom_range(0, 40_000_000);
        hi = lo + $urandom_range(0, 60_000_000);
        case ($urandom_range(0, 7))
            0: lo = '0;
            1: hi = '1;
            2: begin lo = '1; hi = '0; end      // nothing in range
            3: begin hi = lo; lo = lo + $urandom_range(1, 20_000_000); end
            default: ;
        endcase
        write_reg(REG_MASS_MIN, lo);
        write_reg(REG_MASS_MAX, hi);
        write_reg(REG_BINS_REQUESTED, {25'($urandom_range(0, (1 << 24) - 1)), 7'(
            ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(1, 12))});
    endtask

    initial begin
        bins_sb            = new();
        quiet              = 1'b0;
        stall_left         = 0;
        sample_total       = 0;
        aresetn            = 1'b0;
        s_valid            = 1'b0;
        s_sample_mass      = '0;
        s_sample_intensity = '0;
        s_last_sample      = 1'b0;
        m_ready            = 1'b1;
        cfg_valid          = 1'b0;
        cfg_index          = REG_MASS_MIN;
        cfg_data           = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: reset window and field extremes, one sample per bin
        send_sample(32'h0000_0000, 32'h8000_0000, 1'b0);
        send_sample(32'h0001_0000, 32'h7fff_ffff, 1'b0);
        send_sample(32'h0002_0000, 32'h7fff_ffff, 1'b0);
        send_sample(32'h0003_0000, 32'hffff_ffff, 1'b0);
        send_sample(32'hffff_ffff, 32'h0000_0000, 1'b1);
        // single sample spectrum
        send_sample(32'h1234_5678, 32'h8000_0001, 1'b1);
        // zero bins requested acts as one bin
        write_reg(REG_BINS_REQUESTED, 32'd0);
        send_spectrum(4, 1'b1, 32'h0010_0000, 1000);
        // bins above the maximum saturate, then capped by span
        write_reg(REG_BINS_REQUESTED, 32'd127);
        send_spectrum(6, 1'b1, 32'h0020_0000, 1000);
        // empty window
        write_reg(REG_MASS_MIN, 32'hffff_ffff);
        write_reg(REG_MASS_MAX, 32'h0000_0000);
        send_spectrum(4, 1'b1, 32'h0030_0000, 1000);
        // window falls between samples, unsorted masses
        write_reg(REG_MASS_MIN, 32'd35);
        write_reg(REG_MASS_MAX, 32'd15);
        send_sample(32'd10, 32'd1, 1'b0);
        send_sample(32'd20, 32'd2, 1'b0);
        send_sample(32'd30, 32'd3, 1'b0);
        send_sample(32'd40, 32'd4, 1'b1);
        send_spectrum(4, 1'b0, 32'h0, 0);

        // random: mostly sorted spectra under a changing window
        while (sample_total < 250) begin
            random_window();
            repeat ($urandom_range(1, 4)) begin
                if ($urandom_range(0, 7) == 0)
                    send_spectrum($urandom_range(1, 40), 1'b0, 32'h0, 0);
                else if ($urandom_range(0, 7) == 0)
                    send_spectrum($urandom_range(1, 40), 1'b1, $urandom, 1 << 28);
                else
                    send_spectrum($urandom_range(1, 40), 1'b1,
                                  $urandom_range(0, 1 << 24), 1 << 20);
            end
        end

        // final stretch without idling
        quiet = 1'b1;
        random_window();
        repeat (4) send_spectrum($urandom_range(1, 30), 1'b1, 32'h0, 1 << 20);

        drain();
        if (bins_sb.fail_count == 0 && bins_sb.pending_bins.size() == 0) begin
            $display("peak_hold_range_decimator regression: pass");
        end else begin
            $display("peak_hold_range_decimator regression: fail");
        end
        $finish;
    end

    // watchdog
    initial begin
        #4_000_000;
        $display("peak_hold_range_decimator regression: fail");
        $finish;
    end
endmodule

`default_nettype wire
